// ----- rtl/core/tcpd_pkg.sv -----
// Package: shared types, constants and codes of the two-class dispatcher.
package tcpd_pkg;

  localparam int NumW    = 31;
  localparam int RateW   = 16;
  localparam int FuncW   = 2;
  localparam int StatusW = 3;

  localparam int DefHighDepth    = 32;
  localparam int DefLowDepth     = 32;
  localparam int DefHistoryDepth = 64;

  localparam logic [RateW-1:0] ThresholdReset = 16'd192;

  typedef enum logic [FuncW-1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_DISP  = 2'd1,
    FUNC_POP   = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 3'd0,
    ST_DUP   = 3'd1,
    ST_EMPTY = 3'd2,
    ST_FULL  = 3'd3,
    ST_HFULL = 3'd4
  } status_e;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [NumW-1:0]  ticket_number;
    logic [RateW-1:0] rating;
  } req_t;

  typedef struct packed {
    logic [NumW-1:0]    result_number;
    logic [StatusW-1:0] status;
  } rsp_t;

  // Broadcast from the controller to every cell of a chain.
  typedef struct packed {
    logic             ins;    // insert the new entry
    logic             pop;    // remove head, shift toward head
    logic [NumW-1:0]  num;
    logic [RateW-1:0] rate;
  } cell_cmd_t;

  // Per-cell contents seen by the neighbor.
  typedef struct packed {
    logic             vld;
    logic [NumW-1:0]  num;
    logic [RateW-1:0] rate;
  } cell_t;

endpackage

// ----- rtl/core/tcpd_cell.sv -----
// One cell of a shifting chain: sorted insert, FIFO append, head pop, match.
module tcpd_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              sorted_i,   // 1: rating order, 0: arrival order
  input  tcpd_pkg::cell_cmd_t cmd_i,
  input  tcpd_pkg::cell_t   prev_i,     // neighbor toward head
  input  logic              prev_goes_i, // new entry lands at or before prev
  input  tcpd_pkg::cell_t   next_i,     // neighbor toward tail
  output tcpd_pkg::cell_t   cell_o,
  output logic              goes_o,
  output logic              match_o
);
  import tcpd_pkg::*;

  logic             vld_q, vld_d;
  logic [NumW-1:0]  num_q, num_d;
  logic [RateW-1:0] rate_q, rate_d;
  logic             here;

  assign cell_o  = '{vld: vld_q, num: num_q, rate: rate_q};
  assign match_o = vld_q && (num_q == cmd_i.num);

  // New entry goes here or before: first invalid slot, or a lower rating
  assign here   = !vld_q || (sorted_i && (rate_q < cmd_i.rate));
  assign goes_o = here || prev_goes_i;

  // Next contents
  always_comb begin
    vld_d  = vld_q;
    num_d  = num_q;
    rate_d = rate_q;
    if (cmd_i.pop) begin
      vld_d  = next_i.vld;
      num_d  = next_i.num;
      rate_d = next_i.rate;
    end else if (cmd_i.ins) begin
      if (prev_goes_i) begin
        vld_d  = prev_i.vld;
        num_d  = prev_i.num;
        rate_d = prev_i.rate;
      end else if (here) begin
        vld_d  = 1'b1;
        num_d  = cmd_i.num;
        rate_d = cmd_i.rate;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rate_q <= rate_d;
  end
endmodule

// ----- rtl/core/tcpd_chain.sv -----
// A row of cells forming one class store, with head, fullness and match.
module tcpd_chain #(
  parameter int Depth = tcpd_pkg::DefHighDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                sorted_i,
  input  tcpd_pkg::cell_cmd_t cmd_i,
  output tcpd_pkg::cell_t     head_o,
  output logic                full_o,
  output logic                match_o
);
  import tcpd_pkg::*;

  cell_t            cells [Depth];
  logic [Depth-1:0] goes;
  logic [Depth-1:0] match;

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    cell_t prv, nxt;
    logic  pgo;
    if (g == 0) begin : g_first
      assign prv = '0;
      assign pgo = 1'b0;
    end else begin : g_mid
      assign prv = cells[g-1];
      assign pgo = goes[g-1];
    end
    if (g == Depth-1) begin : g_last
      assign nxt = '0;
    end else begin : g_nlast
      assign nxt = cells[g+1];
    end
    tcpd_cell u_cell (
      .clk_i, .rst_ni, .sorted_i, .cmd_i,
      .prev_i(prv), .prev_goes_i(pgo), .next_i(nxt),
      .cell_o(cells[g]), .goes_o(goes[g]), .match_o(match[g])
    );
  end

  assign head_o  = cells[0];
  assign full_o  = cells[Depth-1].vld;
  assign match_o = |match;
endmodule

// ----- rtl/core/two_class_priority_dispatcher.sv -----
// Top level: request decode, two class chains, history stack and APB register.
//  channel | dir | handshake             | payload
//  req     | in  | req_valid_i/req_ready_o | tcpd_pkg::req_t
//  rsp     | out | rsp_valid_o/rsp_ready_i | tcpd_pkg::rsp_t
//  cfg     | in  | APB psel/penable      | rating_threshold at 0x0
// A request is registered on acceptance; in S_DONE it is decoded and compared by
// broadcast against both chains, and the result is registered. The response
// register holds a result while it waits; a new beat is taken only once the
// previous result left, so response back-pressure delays the next beat.
// Reset empties both chains and the history.
// History memory read is registered; its read happens when the request is accepted.
module two_class_priority_dispatcher #(
  parameter int HighDepth    = tcpd_pkg::DefHighDepth,
  parameter int LowDepth     = tcpd_pkg::DefLowDepth,
  parameter int HistoryDepth = tcpd_pkg::DefHistoryDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  tcpd_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output tcpd_pkg::rsp_t rsp_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [1:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import tcpd_pkg::*;

  localparam int HistW = $clog2(HistoryDepth + 1);
  localparam int HistA = $clog2(HistoryDepth);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DONE = 2'b10
  } state_e;

  state_e           state_q, state_d;
  logic [RateW-1:0] thr_q;
  req_t             req_q;
  logic             rsp_valid_q;
  rsp_t             rsp_q;
  logic [HistW-1:0] hcnt_q;
  logic [NumW-1:0]  hist_mem [HistoryDepth];
  logic [NumW-1:0]  hist_rd_q;

  cell_cmd_t hcmd, lcmd;
  cell_t     hhead, lhead;
  logic      hfull, lfull, hmatch, lmatch;

  // APB register
  assign pready = 1'b1;
  assign prdata = {{(32-RateW){1'b0}}, thr_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThresholdReset;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      thr_q <= pwdata[RateW-1:0];
    end
  end

  wire acc = req_valid_i && req_ready_o;
  assign req_ready_o = (state_q == S_IDLE) && !rsp_valid_q;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      req_q <= req_i;
    end
    if (acc && hcnt_q != '0) begin
      hist_rd_q <= hist_mem[HistA'(hcnt_q - 1'b1)];
    end
  end

  // Chains, commanded in S_DONE
  wire is_done  = state_q == S_DONE;
  wire f_add    = is_done && req_q.func == FUNC_ADD;
  wire f_disp   = is_done && req_q.func == FUNC_DISP;
  wire f_pop    = is_done && req_q.func == FUNC_POP;
  wire dup      = hmatch || lmatch;
  wire to_high  = req_q.rating >= thr_q;
  wire hist_ful = hcnt_q >= HistW'(HistoryDepth);

  always_comb begin
    hcmd = '{ins: f_add && !dup && to_high && !hfull,
             pop: f_disp && hhead.vld,
             num: req_q.ticket_number, rate: req_q.rating};
    lcmd = '{ins: f_add && !dup && !to_high && !lfull,
             pop: f_disp && !hhead.vld && lhead.vld,
             num: req_q.ticket_number, rate: req_q.rating};
  end

  tcpd_chain #(.Depth(HighDepth)) u_high (
    .clk_i, .rst_ni, .sorted_i(1'b1), .cmd_i(hcmd),
    .head_o(hhead), .full_o(hfull), .match_o(hmatch));
  tcpd_chain #(.Depth(LowDepth)) u_low (
    .clk_i, .rst_ni, .sorted_i(1'b0), .cmd_i(lcmd),
    .head_o(lhead), .full_o(lfull), .match_o(lmatch));

  // Result
  rsp_t      rsp_d;
  logic [NumW-1:0] got;
  assign got = hhead.vld ? hhead.num : lhead.num;
  always_comb begin
    rsp_d = '{result_number: '0, status: ST_OK};
    case (req_q.func)
      FUNC_ADD: begin
        if (dup) rsp_d.status = ST_DUP;
        else if (to_high ? hfull : lfull) rsp_d.status = ST_FULL;
      end
      FUNC_DISP: begin
        if (!hhead.vld && !lhead.vld) rsp_d.status = ST_EMPTY;
        else begin
          rsp_d.result_number = got;
          if (hist_ful) rsp_d.status = ST_HFULL;
        end
      end
      FUNC_POP: begin
        if (hcnt_q == '0) rsp_d.status = ST_EMPTY;
        else rsp_d.result_number = hist_rd_q;
      end
      default: rsp_d = '{result_number: '0, status: ST_OK};
    endcase
  end

  wire push = f_disp && (hhead.vld || lhead.vld) && !hist_ful;
  always_ff @(posedge clk_i) begin
    if (push) begin
      hist_mem[HistA'(hcnt_q)] <= got;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (acc) state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
      hcnt_q      <= '0;
    end else begin
      state_q <= state_d;
      if (is_done) rsp_valid_q <= 1'b1;
      else if (rsp_ready_i) rsp_valid_q <= 1'b0;
      if (push) hcnt_q <= hcnt_q + 1'b1;
      else if (f_pop && hcnt_q != '0) hcnt_q <= hcnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_done) rsp_q <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;
endmodule
